// File: hdl/pcrx_pkg.sv
// Shared types, constants and SHA-1 round functions for the PCR replay block.
package pcrx_pkg;

    // Default accumulator count
    localparam int NUM_PCRS_DEF = 8;

    // Field widths of the event and result items
    localparam int PCR_W    = 5;
    localparam int WORD_W   = 32;
    localparam int DIGEST_W = 160;
    localparam int MSG_W    = 320;
    localparam int MSG_WORDS = MSG_W / WORD_W;

    // Event-log codes
    localparam logic [31:0] NO_ACTION_TYPE      = 32'd3;
    localparam logic [31:0] LOCALITY_EVENT_SIZE = 32'd17;
    localparam logic [63:0] LOC_SIG_HI          = 64'h537461727475704C;
    localparam logic [63:0] LOC_SIG_LO          = 64'h6F63616C69747900;

    // SHA-1 initial chaining value
    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [31:0] IV_E = 32'hC3D2E1F0;

    // Padding of a 40-byte message: end marker and bit length
    localparam logic [31:0] PAD_WORD = 32'h80000000;
    localparam logic [31:0] LEN_WORD = 32'd320;

    localparam logic [6:0] LAST_ROUND = 7'd79;

    typedef logic [MSG_W-1:0]    t_msg;
    typedef logic [DIGEST_W-1:0] t_digest;

    // Hash unit status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_sha_status;

    typedef enum logic [1:0] {
        SH_IDLE,
        SH_ROUND,
        SH_FINAL
    } t_sha_state;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_HASH,
        ST_OUT
    } t_state;

    // Round function selected by round number
    function automatic logic [31:0] sha1_f(input logic [6:0] rnd, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (rnd < 7'd20) begin
            f = (b & c) | (~b & d);
        end else if (rnd < 7'd40) begin
            f = b ^ c ^ d;
        end else if (rnd < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

    // Round constant selected by round number
    function automatic logic [31:0] sha1_k(input logic [6:0] rnd);
        logic [31:0] k;
        if (rnd < 7'd20) begin
            k = 32'h5A827999;
        end else if (rnd < 7'd40) begin
            k = 32'h6ED9EBA1;
        end else if (rnd < 7'd60) begin
            k = 32'h8F1BBCDC;
        end else begin
            k = 32'hCA62C1D6;
        end
        return k;
    endfunction

endpackage

// File: hdl/pcrx_sha1_core.sv
// Iterative SHA-1 compression of one padded 40-byte message, one round per cycle.
module pcrx_sha1_core
    import pcrx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_msg        i_msg,
    output t_digest     o_digest,
    output t_sha_status o_status
);

    t_sha_state r_state;
    t_sha_state n_state;

    logic [6:0]  r_round;
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_w [16];
    logic        r_done;
    t_digest     r_digest;

    logic [31:0] w_new;
    logic [31:0] t_sum;
    logic        round_en;
    logic        load_en;
    logic        final_en;

    // Message schedule and round sum
    assign w_new = {r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0]} << 1
                 | {r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0]} >> 31;
    assign t_sum = {r_a[26:0], r_a[31:27]} + sha1_f(r_round, r_b, r_c, r_d)
                 + r_e + sha1_k(r_round) + r_w[0];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            SH_IDLE: begin
                if (i_start) begin
                    n_state = SH_ROUND;
                end
            end
            SH_ROUND: begin
                if (r_round == LAST_ROUND) begin
                    n_state = SH_FINAL;
                end
            end
            SH_FINAL: begin
                n_state = SH_IDLE;
            end
            default: begin
                n_state = SH_IDLE;
            end
        endcase
    end

    // Datapath enables
    always_comb begin
        load_en  = 1'b0;
        round_en = 1'b0;
        final_en = 1'b0;
        case (r_state)
            SH_IDLE:  load_en  = i_start;
            SH_ROUND: round_en = 1'b1;
            SH_FINAL: final_en = 1'b1;
            default:  load_en  = 1'b0;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= final_en;
        end
    end

    // Working variables, schedule ring and round counter
    always_ff @(posedge i_clk) begin
        if (load_en) begin
            for (int i = 0; i < MSG_WORDS; i++) begin
                r_w[i] <= i_msg[MSG_W-1-WORD_W*i -: WORD_W];
            end
            r_w[MSG_WORDS] <= PAD_WORD;
            for (int i = MSG_WORDS + 1; i < 15; i++) begin
                r_w[i] <= '0;
            end
            r_w[15] <= LEN_WORD;
            r_a     <= IV_A;
            r_b     <= IV_B;
            r_c     <= IV_C;
            r_d     <= IV_D;
            r_e     <= IV_E;
            r_round <= '0;
        end else if (round_en) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_new;
            r_e     <= r_d;
            r_d     <= r_c;
            r_c     <= {r_b[1:0], r_b[31:2]};
            r_b     <= r_a;
            r_a     <= t_sum;
            r_round <= r_round + 7'd1;
        end
    end

    // Add the chaining value
    always_ff @(posedge i_clk) begin
        if (final_en) begin
            r_digest <= {IV_A + r_a, IV_B + r_b, IV_C + r_c, IV_D + r_d, IV_E + r_e};
        end
    end

    assign o_digest      = r_digest;
    assign o_status.busy = (r_state != SH_IDLE);
    assign o_status.done = r_done;

endmodule

// File: hdl/pcr_extend_replay_sha1.sv
// Top level: PCR accumulator bank, event sequencer and result register.
//
//  channel | dir | fields (lowest bit first)
//  s_*     | in  | tuser: start_of_log; tdata: pcr_index, event_type, event_size,
//          |     |   digest_hi, digest_mid, digest_lo, sig_hi, sig_lo, locality_byte
//  m_*     | out | tuser: extended, locality_applied; tdata: out_pcr, value_hi,
//          |     |   value_mid, value_lo
//
// An extending event passes through ST_LOAD, ST_HASH and ST_OUT before the next
// acceptance; ST_HASH waits on the 80 rounds of the shared SHA-1 unit and its load
// and finish steps. Other events go from ST_LOAD straight to ST_OUT. One event is
// in flight at a time; s_tready is low while it is worked. The result register lets
// the next event enter while a result waits on m_tready. Reset (i_rst_n low,
// synchronous) zeroes all PCRs.
module pcr_extend_replay_sha1
    import pcrx_pkg::*;
#(
    parameter int NUM_PCRS = NUM_PCRS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pcr_index, event_type, event_size, digest_hi, digest_mid, digest_lo,
    // sig_hi, sig_lo, locality_byte, zero fill
    input  logic [367:0] s_tdata,
    // start_of_log
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_pcr, value_hi, value_mid, value_lo, zero fill
    output logic [167:0] m_tdata,
    // extended, locality_applied
    output logic [1:0]   m_tuser
);

    localparam int IDX_W = (NUM_PCRS > 1) ? $clog2(NUM_PCRS) : 1;

    t_state r_state;
    t_state n_state;

    // Captured event
    logic [PCR_W-1:0] r_pcr;
    logic [31:0]      r_type;
    logic [31:0]      r_size;
    t_digest          r_dig;
    logic [63:0]      r_sig_hi;
    logic [63:0]      r_sig_lo;
    logic [7:0]       r_loc;

    // Accumulator bank; an entry that is not valid reads as zero
    t_digest             r_acc [NUM_PCRS];
    logic [NUM_PCRS-1:0] r_acc_vld;

    // Result ahead of the output register
    logic            r_res_ext;
    logic            r_res_loc;
    t_digest         r_res_val;

    logic             r_m_valid;
    logic [PCR_W-1:0] r_m_pcr;
    logic             r_m_ext;
    logic             r_m_loc;
    t_digest          r_m_val;

    logic        in_accept;
    logic        in_range;
    logic        do_hash;
    logic        is_locality;
    logic        core_start;
    logic        out_load;
    logic [IDX_W-1:0] idx;
    t_digest     acc_rd;
    t_digest     loc_val;
    t_digest     core_digest;
    t_sha_status core_status;

    assign in_accept = s_tvalid && s_tready;
    assign idx       = r_pcr[IDX_W-1:0];
    assign in_range  = ({1'b0, r_pcr} < 6'(NUM_PCRS));
    assign do_hash   = in_range && (r_type != NO_ACTION_TYPE);
    assign acc_rd    = (in_range && r_acc_vld[idx]) ? r_acc[idx] : '0;
    assign loc_val   = {acc_rd[DIGEST_W-1:8], r_loc};

    // Recognize a startup locality event
    assign is_locality = (r_pcr == '0) && (r_type == NO_ACTION_TYPE)
                      && (r_size == LOCALITY_EVENT_SIZE)
                      && (r_sig_hi == LOC_SIG_HI) && (r_sig_lo == LOC_SIG_LO);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_state = do_hash ? ST_HASH : ST_OUT;
            end
            ST_HASH: begin
                if (core_status.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_tready   = 1'b0;
        core_start = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            ST_IDLE: s_tready   = 1'b1;
            ST_LOAD: core_start = do_hash;
            ST_OUT:  out_load   = !r_m_valid || m_tready;
            default: s_tready   = 1'b0;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_acc_vld <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_accept && s_tuser[0]) begin
                r_acc_vld <= '0;
            end else if (r_state == ST_LOAD && is_locality) begin
                r_acc_vld[0] <= 1'b1;
            end else if (r_state == ST_HASH && core_status.done) begin
                r_acc_vld[idx] <= 1'b1;
            end
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Capture the event
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pcr    <= s_tdata[4:0];
            r_type   <= s_tdata[36:5];
            r_size   <= s_tdata[68:37];
            r_dig    <= {s_tdata[132:69], s_tdata[196:133], s_tdata[228:197]};
            r_sig_hi <= s_tdata[292:229];
            r_sig_lo <= s_tdata[356:293];
            r_loc    <= s_tdata[364:357];
        end
    end

    // Write back the accumulator and stage the result
    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOAD) begin
            r_res_ext <= 1'b0;
            r_res_loc <= is_locality;
            r_res_val <= is_locality ? loc_val : acc_rd;
            if (is_locality) begin
                r_acc[0] <= loc_val;
            end
        end else if (r_state == ST_HASH && core_status.done) begin
            r_res_ext  <= 1'b1;
            r_res_loc  <= 1'b0;
            r_res_val  <= core_digest;
            r_acc[idx] <= core_digest;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_pcr <= r_pcr;
            r_m_ext <= r_res_ext;
            r_m_loc <= r_res_loc;
            r_m_val <= r_res_val;
        end
    end

    pcrx_sha1_core u_sha1 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (core_start),
        .i_msg    ({acc_rd, r_dig}),
        .o_digest (core_digest),
        .o_status (core_status)
    );

    // Place value_hi right above out_pcr, then value_mid, then value_lo
    assign m_tvalid = r_m_valid;
    assign m_tdata  = {3'b000, r_m_val[31:0], r_m_val[95:32], r_m_val[159:96], r_m_pcr};
    assign m_tuser  = {r_m_loc, r_m_ext};

`ifndef SYNTHESIS
    // Start the hash unit only when it is free
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_start |-> !core_status.busy)
        else $error("hash unit started while busy");

    // A hash result arrives only while the sequencer waits for it
    a_done_in_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_status.done |-> (r_state == ST_HASH))
        else $error("hash result outside the hash wait");

    // No result both extends and applies a locality
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("extended and locality flags both set");

    // An extended result never reports an out-of-range PCR
    a_ext_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser[0]) |-> ({1'b0, m_tdata[4:0]} < 6'(NUM_PCRS)))
        else $error("extend reported for an out-of-range PCR");
`endif

endmodule

// File: tb/sv/tb_pcr_extend_replay_sha1.sv
// Self-checking testbench for the SHA-1 PCR event-log replay block.
module tb_pcr_extend_replay_sha1;
    import pcrx_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PCR_COUNT = 8;
    localparam int RANDOM_EVENTS = 1725;
    localparam int DRAIN_CYCLES = 100;

    // One log event as it travels on s_tuser / s_tdata
    typedef struct packed {
        logic        sol;
        logic [4:0]  pcr;
        logic [31:0] etype;
        logic [31:0] esize;
        logic [63:0] dhi;
        logic [63:0] dmid;
        logic [31:0] dlo;
        logic [63:0] shi;
        logic [63:0] slo;
        logic [7:0]  loc;
    } t_log_event;

    // One PCR report as it travels on m_tuser / m_tdata
    typedef struct packed {
        logic [4:0]  pcr;
        logic        ext;
        logic        loc_ap;
        logic [63:0] vhi;
        logic [63:0] vmid;
        logic [31:0] vlo;
    } t_pcr_report;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // pcr_index, event_type, event_size, digest_hi, digest_mid, digest_lo,
    // sig_hi, sig_lo, locality_byte, zero fill
    logic [367:0] s_tdata = '0;
    // start_of_log
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // out_pcr, value_hi, value_mid, value_lo, zero fill
    logic [167:0] m_tdata;
    // extended, locality_applied
    logic [1:0]   m_tuser;

    // Predicted accumulator bank and the reports still owed by the block
    logic [159:0] pcr_bank [PCR_COUNT];
    t_pcr_report  pending_reports[$];
    int unsigned  error_count = 0;
    bit           idle_en = 1'b1;
    int unsigned  rx_hold_req = 0;

    pcr_extend_replay_sha1 #(
        .NUM_PCRS (PCR_COUNT)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest correct run
    initial begin
        #12_000_000;
        $display("tb_pcr_extend_replay_sha1: done, errors");
        $finish;
    end

    // Gap length for either side: mostly none or short, a few long
    function automatic int unsigned idle_len();
        int unsigned roll;
        roll = $urandom_range(99);
        if (!idle_en || roll < 55) begin
            return 0;
        end
        if (roll < 92) begin
            return $urandom_range(4, 1);
        end
        return $urandom_range(30, 10);
    endfunction

    // SHA-1 of the 40-byte message prev || dig, one padded block
    function automatic logic [159:0] sha1_chain(input logic [159:0] prev,
                                               input logic [159:0] dig);
        logic [31:0]  w [80];
        logic [319:0] msg;
        logic [31:0]  a, b, c, d, e, f, k, t, x;
        msg = {prev, dig};
        for (int i = 0; i < 10; i++) begin
            w[i] = msg[319 - 32 * i -: 32];
        end
        w[10] = PAD_WORD;
        for (int i = 11; i < 15; i++) begin
            w[i] = '0;
        end
        w[15] = LEN_WORD;
        for (int i = 16; i < 80; i++) begin
            x = w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16];
            w[i] = {x[30:0], x[31]};
        end
        a = IV_A; b = IV_B; c = IV_C; d = IV_D; e = IV_E;
        for (int i = 0; i < 80; i++) begin
            case (i / 20)
                0: begin
                    f = (b & c) | (~b & d);
                    k = 32'h5A827999;
                end
                1: begin
                    f = b ^ c ^ d;
                    k = 32'h6ED9EBA1;
                end
                2: begin
                    f = (b & c) | (b & d) | (c & d);
                    k = 32'h8F1BBCDC;
                end
                default: begin
                    f = b ^ c ^ d;
                    k = 32'hCA62C1D6;
                end
            endcase
            t = {a[26:0], a[31:27]} + f + e + k + w[i];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        return {IV_A + a, IV_B + b, IV_C + c, IV_D + d, IV_E + e};
    endfunction

    // Apply one event to the predicted bank and return the report it causes
    function automatic t_pcr_report replay_event(input t_log_event ev);
        t_pcr_report rep;
        rep = '0;
        rep.pcr = ev.pcr;
        if (ev.sol) begin
            for (int p = 0; p < PCR_COUNT; p++) begin
                pcr_bank[p] = '0;
            end
        end
        if (ev.pcr < PCR_COUNT) begin
            if (ev.pcr == 5'd0 && ev.etype == NO_ACTION_TYPE &&
                ev.esize == LOCALITY_EVENT_SIZE &&
                ev.shi == LOC_SIG_HI && ev.slo == LOC_SIG_LO) begin
                pcr_bank[0][7:0] = ev.loc;
                rep.loc_ap = 1'b1;
            end
            if (ev.etype != NO_ACTION_TYPE) begin
                pcr_bank[ev.pcr] = sha1_chain(pcr_bank[ev.pcr], {ev.dhi, ev.dmid, ev.dlo});
                rep.ext = 1'b1;
            end
            {rep.vhi, rep.vmid, rep.vlo} = pcr_bank[ev.pcr];
        end
        return rep;
    endfunction

    // Event with random digest and data bytes
    function automatic t_log_event make_event(input logic sol, input logic [4:0] pcr,
                                              input logic [31:0] etype,
                                              input logic [31:0] esize);
        t_log_event ev;
        ev.sol = sol;
        ev.pcr = pcr;
        ev.etype = etype;
        ev.esize = esize;
        ev.dhi = {$urandom, $urandom};
        ev.dmid = {$urandom, $urandom};
        ev.dlo = $urandom;
        ev.shi = {$urandom, $urandom};
        ev.slo = {$urandom, $urandom};
        ev.loc = 8'($urandom);
        return ev;
    endfunction

    // Well-formed startup locality event
    function automatic t_log_event locality_event(input logic sol, input logic [7:0] loc);
        t_log_event ev;
        ev = make_event(sol, 5'd0, NO_ACTION_TYPE, LOCALITY_EVENT_SIZE);
        ev.shi = LOC_SIG_HI;
        ev.slo = LOC_SIG_LO;
        ev.loc = loc;
        return ev;
    endfunction

    // Offer one item after a random gap, hold it until accepted, then predict
    task automatic send_event(input t_log_event ev);
        int unsigned gap;
        gap = idle_len();
        @(negedge i_clk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= ev.sol;
        s_tdata <= {3'b0, ev.loc, ev.slo, ev.shi, ev.dlo, ev.dmid, ev.dhi,
                    ev.esize, ev.etype, ev.pcr};
        do @(posedge i_clk); while (!s_tready);
        pending_reports.push_back(replay_event(ev));
    endtask

    // Output side: random stalls, plus a long hold-off when one is requested
    initial begin : rx_side
        int unsigned stall_left;
        stall_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_hold_req != 0) begin
                stall_left = rx_hold_req;
                rx_hold_req = 0;
            end else if (stall_left == 0 && $urandom_range(3) == 0) begin
                stall_left = idle_len();
            end
            if (stall_left != 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            error_count++;
        end
    endfunction

    // Compare each accepted report with the oldest prediction
    always @(posedge i_clk) begin
        t_pcr_report exp_r;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t ns: unexpected report, expected none, got tuser %0h tdata %0h",
                         $time, m_tuser, m_tdata);
                error_count++;
            end else begin
                exp_r = pending_reports.pop_front();
                check_field("out_pcr", 64'(exp_r.pcr), 64'(m_tdata[4:0]));
                check_field("extended", 64'(exp_r.ext), 64'(m_tuser[0]));
                check_field("locality_applied", 64'(exp_r.loc_ap), 64'(m_tuser[1]));
                check_field("value_hi", exp_r.vhi, m_tdata[68:5]);
                check_field("value_mid", exp_r.vmid, m_tdata[132:69]);
                check_field("value_lo", 64'(exp_r.vlo), 64'(m_tdata[164:133]));
            end
        end
    end

    // Extends at the field extremes, on the first and last PCR
    task automatic test_extend_extremes();
        t_log_event ev;
        ev = make_event(1'b1, 5'd0, '0, '0);
        ev.dhi = '0; ev.dmid = '0; ev.dlo = '0; ev.shi = '0; ev.slo = '0; ev.loc = '0;
        send_event(ev);
        ev = make_event(1'b0, 5'd7, '1, '1);
        ev.dhi = '1; ev.dmid = '1; ev.dlo = '1; ev.shi = '1; ev.slo = '1; ev.loc = '1;
        send_event(ev);
        send_event(make_event(1'b0, 5'd7, 32'd4, 32'd20));
        send_event(make_event(1'b0, 5'd0, 32'd2, 32'd0));
        // no-action event that is not a locality event leaves the PCR alone
        send_event(make_event(1'b0, 5'd7, NO_ACTION_TYPE, 32'd5));
    endtask

    // Startup locality and near misses of it
    task automatic test_locality_events();
        t_log_event ev;
        send_event(locality_event(1'b0, 8'h03));
        send_event(locality_event(1'b0, 8'hFF));
        send_event(locality_event(1'b0, 8'h00));
        ev = locality_event(1'b0, 8'h04);
        ev.esize = 32'd16;
        send_event(ev);
        ev = locality_event(1'b0, 8'h04);
        ev.esize = 32'd18;
        send_event(ev);
        ev = locality_event(1'b0, 8'h04);
        ev.slo[0] = 1'b1;
        send_event(ev);
        ev = locality_event(1'b0, 8'h04);
        ev.shi[63] = 1'b1;
        send_event(ev);
        ev = locality_event(1'b0, 8'h04);
        ev.pcr = 5'd1;
        send_event(ev);
        // right signature but an extending type: extend only
        ev = locality_event(1'b0, 8'h04);
        ev.etype = 32'd1;
        send_event(ev);
        // clear and set locality in one event
        send_event(locality_event(1'b1, 8'h02));
        send_event(make_event(1'b0, 5'd0, 32'd8, 32'd32));
    endtask

    // Out-of-range PCRs and the clear they may still carry
    task automatic test_ignored_and_cleared();
        send_event(make_event(1'b0, 5'd8, 32'd4, 32'd20));
        send_event(make_event(1'b0, 5'd31, 32'd0, 32'd0));
        send_event(make_event(1'b1, 5'd20, NO_ACTION_TYPE, LOCALITY_EVENT_SIZE));
        send_event(make_event(1'b0, 5'd0, NO_ACTION_TYPE, 32'd0));
        send_event(make_event(1'b0, 5'd7, 32'd5, 32'd1));
    endtask

    // Hold the output off for a long stretch while items keep coming
    task automatic test_output_stall();
        idle_en = 1'b0;
        rx_hold_req = 300;
        for (int n = 0; n < 8; n++) begin
            if (n % 3 == 0) begin
                send_event(make_event(1'b0, 5'($urandom_range(7)), 32'd13, 32'd20));
            end else begin
                send_event(make_event(1'b0, 5'($urandom_range(31)), NO_ACTION_TYPE,
                                      $urandom));
            end
        end
        idle_en = 1'b1;
    endtask

    // Log-like random events: mostly extends and locality, some broken and noise
    task automatic test_random_log();
        t_log_event  ev;
        int unsigned kind;
        int unsigned bit_pos;
        logic        sol;
        for (int n = 0; n < RANDOM_EVENTS; n++) begin
            // every 40 events, pick at random whether the next stretch idles
            if (n % 40 == 0) begin
                idle_en = ($urandom_range(3) != 0);
            end
            sol = ($urandom_range(99) < 3);
            kind = $urandom_range(99);
            bit_pos = $urandom_range(63);
            if (kind < 65) begin
                ev = make_event(sol, ($urandom_range(9) == 0) ? 5'($urandom_range(31))
                                                               : 5'($urandom_range(7)),
                                $urandom, $urandom);
                if (ev.etype == NO_ACTION_TYPE) begin
                    ev.etype = '0;
                end
            end else if (kind < 75) begin
                ev = make_event(sol, 5'($urandom_range(31)), NO_ACTION_TYPE,
                                $urandom_range(1) ? LOCALITY_EVENT_SIZE : $urandom);
            end else if (kind < 88) begin
                ev = locality_event(sol, 8'($urandom));
            end else begin
                ev = locality_event(sol, 8'($urandom));
                case ($urandom_range(3))
                    0: ev.shi[bit_pos] = ~ev.shi[bit_pos];
                    1: ev.slo[bit_pos] = ~ev.slo[bit_pos];
                    2: ev.esize[bit_pos % 32] = ~ev.esize[bit_pos % 32];
                    default: ev.pcr = 5'($urandom_range(31, 1));
                endcase
            end
            send_event(ev);
        end
        idle_en = 1'b1;
    endtask

    // Release the input, drain the reports and report the verdict
    task automatic finish_run();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_pcr_extend_replay_sha1: done, clean");
        end else begin
            $display("tb_pcr_extend_replay_sha1: done, errors");
        end
        $finish;
    endtask

    initial begin
        for (int p = 0; p < PCR_COUNT; p++) begin
            pcr_bank[p] = '0;
        end
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_extend_extremes();
        test_locality_events();
        test_ignored_and_cleared();
        test_output_stall();
        test_random_log();
        finish_run();
    end

endmodule

// File: files.f
hdl/pcrx_pkg.sv
hdl/pcrx_sha1_core.sv
hdl/pcr_extend_replay_sha1.sv
tb/sv/tb_pcr_extend_replay_sha1.sv
